FILE: hw/rtl/svm_pkg.sv
// Shared types, opcodes and constants of the stack virtual machine core.
// No dependencies; used by every module under hw/rtl.
package svm_pkg;

  localparam int MemWords = 4096;
  localparam int CodeWords = 4096;
  localparam int DataWidth = 32;

  typedef enum logic [5:0] {
    OP_LEA = 6'd0, OP_IMM = 6'd1, OP_JMP = 6'd2, OP_CALL = 6'd3, OP_JZ = 6'd4,
    OP_JNZ = 6'd5, OP_ENT = 6'd6, OP_ADJ = 6'd7, OP_LEV = 6'd8, OP_LI = 6'd9,
    OP_LC = 6'd10, OP_SI = 6'd11, OP_SC = 6'd12, OP_PUSH = 6'd13, OP_OR = 6'd14,
    OP_XOR = 6'd15, OP_AND = 6'd16, OP_EQ = 6'd17, OP_NE = 6'd18, OP_LT = 6'd19,
    OP_GT = 6'd20, OP_LE = 6'd21, OP_GE = 6'd22, OP_SHL = 6'd23, OP_SHR = 6'd24,
    OP_ADD = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27, OP_DIV = 6'd28, OP_MOD = 6'd29,
    OP_EXIT = 6'd37
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNSUP = 2'd1, ST_DIVZ = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_READ2, S_DIV, S_OUT
  } state_t;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic start;
    logic is_mod;
  } div_ctl_t;

endpackage

FILE: hw/rtl/svm_divider.sv
// Restoring divider, one quotient bit per cycle, signed operands.
// Depends on svm_pkg for the control struct.
module svm_divider #(
  parameter int DataWidth = svm_pkg::DataWidth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  svm_pkg::div_ctl_t    ctl,
  input  logic [DataWidth-1:0] dividend,
  input  logic [DataWidth-1:0] divisor,
  output logic                 done,
  output logic [DataWidth-1:0] result
);

  localparam int CntW = $clog2(DataWidth + 1);

  logic [DataWidth-1:0] quo;
  logic [DataWidth-1:0] rem;
  logic [DataWidth-1:0] dsr;
  logic [CntW-1:0]      cnt;
  logic                 busy;
  logic                 neg_q;
  logic                 neg_r;
  logic                 is_mod;
  logic [DataWidth:0]   trial;
  logic [DataWidth:0]   shifted;

  assign shifted = {rem, quo[DataWidth-1]};
  assign trial = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= CntW'(DataWidth);
        quo <= dividend[DataWidth-1] ? -dividend : dividend;
        dsr <= divisor[DataWidth-1] ? -divisor : divisor;
        rem <= '0;
        neg_q <= dividend[DataWidth-1] ^ divisor[DataWidth-1];
        neg_r <= dividend[DataWidth-1];
        is_mod <= ctl.is_mod;
      end else if (busy) begin
        if (!trial[DataWidth]) begin
          rem <= trial[DataWidth-1:0];
          quo <= {quo[DataWidth-2:0], 1'b1};
        end else begin
          rem <= shifted[DataWidth-1:0];
          quo <= {quo[DataWidth-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (is_mod) result = neg_r ? -rem : rem;
    else        result = neg_q ? -quo : quo;
  end

endmodule

FILE: hw/rtl/svm_stack_mem.sv
// Word memory of the core: one write port, one registered read port.
// Takes its default sizes from svm_pkg.
module svm_stack_mem #(
  parameter int DataWidth = svm_pkg::DataWidth,
  parameter int MemWords = svm_pkg::MemWords
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(MemWords)-1:0] waddr,
  input  logic [DataWidth-1:0]        wdata,
  input  logic [$clog2(MemWords)-1:0] raddr,
  output logic [DataWidth-1:0]        rdata
);

  logic [DataWidth-1:0] mem [MemWords];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/stack_vm_instruction_executor_unit.sv
// Top level of the stack virtual machine core: sequencer, ALU and registers.
// Depends on svm_pkg, svm_stack_mem and svm_divider.
//
// One instruction is accepted at a time and passes IDLE and OUT. Those that
// read the stack or data memory also pass READ; LEV, which reads two words
// through the single read port, READ and READ2; DIV and MOD with a nonzero
// divisor also DIV, to wait for the bit-serial divider. The result sits in an
// output register until taken; the next instruction is accepted once it is.
module stack_vm_instruction_executor_unit #(
  parameter int MemWords = svm_pkg::MemWords,
  parameter int CodeWords = svm_pkg::CodeWords,
  parameter int DataWidth = svm_pkg::DataWidth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DataWidth+7:0] s_tdata,   // opcode[5:0], operand, zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // next_pc, acc_value, halted, status, exit_code, zero pad
  output logic [((2*DataWidth+$clog2(CodeWords)+3+7)/8)*8-1:0] m_tdata
);

  localparam int AW = $clog2(MemWords);
  localparam int PW = AW + 1;
  localparam int CW = $clog2(CodeWords);
  localparam int OutW = 2 * DataWidth + CW + 3;
  localparam int OutBytesW = ((OutW + 7) / 8) * 8;

  svm_pkg::state_t state, state_next;
  logic [CW-1:0]        pc;
  logic [PW-1:0]        sp;
  logic [PW-1:0]        bp;
  logic [DataWidth-1:0] acc;
  logic                 halt;
  logic [5:0]           opc;
  logic [1:0]           status;
  logic [DataWidth-1:0] exitv;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [DataWidth-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [DataWidth-1:0] rdata;
  svm_pkg::div_ctl_t    dctl;
  logic                 ddone;
  logic [DataWidth-1:0] dres;

  logic [5:0]           in_opc;
  logic [DataWidth-1:0] in_opnd;
  logic                 take;

  assign in_opc  = s_tdata[5:0];
  assign in_opnd = s_tdata[DataWidth+5:6];
  assign s_tready = (state == svm_pkg::S_IDLE);
  assign take = s_tvalid && s_tready;
  assign m_tvalid = (state == svm_pkg::S_OUT);
  assign m_tdata = OutBytesW'({exitv, status, halt, acc, pc});

  svm_stack_mem #(.DataWidth(DataWidth), .MemWords(MemWords)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  svm_divider #(.DataWidth(DataWidth)) u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .dividend(rdata), .divisor(acc),
    .done(ddone), .result(dres)
  );

  // Code target: low bits of the signed word are its value modulo CodeWords.
  function automatic logic [CW-1:0] code_of(input logic [DataWidth-1:0] v);
    code_of = v[CW-1:0];
  endfunction

  logic is_alu, is_div;
  always_comb begin
    is_alu = (opc >= svm_pkg::OP_OR) && (opc <= svm_pkg::OP_MOD);
    is_div = (opc == svm_pkg::OP_DIV) || (opc == svm_pkg::OP_MOD);
  end

  // Read address of the first (or, for LEV, the second) memory word.
  always_comb begin
    if (state == svm_pkg::S_READ && opc == svm_pkg::OP_LEV) raddr = AW'(bp + 1'b1);
    else if (state == svm_pkg::S_IDLE && (in_opc == svm_pkg::OP_LI
             || in_opc == svm_pkg::OP_LC)) raddr = acc[AW-1:0];
    else if (state == svm_pkg::S_IDLE && in_opc == svm_pkg::OP_LEV) raddr = bp[AW-1:0];
    else raddr = sp[AW-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      svm_pkg::S_IDLE: if (take) begin
        if (halt) state_next = svm_pkg::S_OUT;
        else if (in_opc >= svm_pkg::OP_OR && in_opc <= svm_pkg::OP_MOD
                 || in_opc == svm_pkg::OP_LEV || in_opc == svm_pkg::OP_LI
                 || in_opc == svm_pkg::OP_LC || in_opc == svm_pkg::OP_SI
                 || in_opc == svm_pkg::OP_SC || in_opc == svm_pkg::OP_EXIT)
          state_next = svm_pkg::S_READ;
        else state_next = svm_pkg::S_OUT;
      end
      svm_pkg::S_READ: begin
        if (opc == svm_pkg::OP_LEV) state_next = svm_pkg::S_READ2;
        else if (is_div && acc != '0) state_next = svm_pkg::S_DIV;
        else state_next = svm_pkg::S_OUT;
      end
      svm_pkg::S_READ2: state_next = svm_pkg::S_OUT;
      svm_pkg::S_DIV: if (ddone) state_next = svm_pkg::S_OUT;
      svm_pkg::S_OUT: if (m_tready) state_next = svm_pkg::S_IDLE;
      default: state_next = svm_pkg::S_IDLE;
    endcase
  end

  // Memory writes: pushes for CALL, ENT and PUSH happen in the accept cycle;
  // stores happen once the address word has been read.
  always_comb begin
    we = 1'b0;
    waddr = AW'(sp - 1'b1);
    wdata = acc;
    dctl = '0;
    if (take && !halt) begin
      unique case (in_opc)
        svm_pkg::OP_CALL: begin we = 1'b1; wdata = DataWidth'(pc + CW'(2)); end
        svm_pkg::OP_ENT:  begin we = 1'b1; wdata = DataWidth'(bp); end
        svm_pkg::OP_PUSH: we = 1'b1;
        default: we = 1'b0;
      endcase
    end
    if (state == svm_pkg::S_READ) begin
      waddr = rdata[AW-1:0];
      if (opc == svm_pkg::OP_SI) we = 1'b1;
      if (opc == svm_pkg::OP_SC) begin
        we = 1'b1;
        wdata = DataWidth'(signed'(acc[7:0]));
      end
      dctl.start = is_div && acc != '0;
      dctl.is_mod = (opc == svm_pkg::OP_MOD);
    end
  end

  logic [DataWidth-1:0] alu;
  logic                 lt;
  always_comb begin
    lt = $signed(rdata) < $signed(acc);
    alu = acc;
    unique case (opc)
      svm_pkg::OP_OR:  alu = rdata | acc;
      svm_pkg::OP_XOR: alu = rdata ^ acc;
      svm_pkg::OP_AND: alu = rdata & acc;
      svm_pkg::OP_EQ:  alu = DataWidth'(rdata == acc);
      svm_pkg::OP_NE:  alu = DataWidth'(rdata != acc);
      svm_pkg::OP_LT:  alu = DataWidth'(lt);
      svm_pkg::OP_GT:  alu = DataWidth'(!lt && rdata != acc);
      svm_pkg::OP_LE:  alu = DataWidth'(lt || rdata == acc);
      svm_pkg::OP_GE:  alu = DataWidth'(!lt);
      svm_pkg::OP_SHL:
        alu = ($signed(acc) < 0 || acc >= DataWidth'(DataWidth)) ? '0 : rdata << acc;
      svm_pkg::OP_SHR:
        alu = ($signed(acc) < 0 || acc >= DataWidth'(DataWidth))
          ? {DataWidth{rdata[DataWidth-1]}} : DataWidth'($signed(rdata) >>> acc);
      svm_pkg::OP_ADD: alu = rdata + acc;
      svm_pkg::OP_SUB: alu = rdata - acc;
      svm_pkg::OP_MUL: alu = rdata * acc;
      default: alu = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svm_pkg::S_IDLE;
      pc <= '0;
      sp <= PW'(MemWords);
      bp <= PW'(MemWords);
      acc <= '0;
      halt <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        opc <= in_opc;
        status <= svm_pkg::ST_OK;
        exitv <= '0;
        if (!halt) begin
          pc <= pc + 1'b1;
          unique case (in_opc)
            svm_pkg::OP_LEA: begin acc <= DataWidth'(bp) + in_opnd; pc <= pc + CW'(2); end
            svm_pkg::OP_IMM: begin acc <= in_opnd; pc <= pc + CW'(2); end
            svm_pkg::OP_JMP: pc <= code_of(in_opnd);
            svm_pkg::OP_CALL: begin sp <= sp - 1'b1; pc <= code_of(in_opnd); end
            svm_pkg::OP_JZ: pc <= (acc == '0) ? code_of(in_opnd) : pc + CW'(2);
            svm_pkg::OP_JNZ: pc <= (acc != '0) ? code_of(in_opnd) : pc + CW'(2);
            svm_pkg::OP_ENT: begin
              bp <= sp - 1'b1;
              sp <= sp - 1'b1 - PW'(in_opnd);
              pc <= pc + CW'(2);
            end
            svm_pkg::OP_ADJ: begin sp <= sp + PW'(in_opnd); pc <= pc + CW'(2); end
            svm_pkg::OP_LEV: sp <= bp + PW'(2);
            svm_pkg::OP_PUSH: sp <= sp - 1'b1;
            svm_pkg::OP_LI, svm_pkg::OP_LC, svm_pkg::OP_SI, svm_pkg::OP_SC,
            svm_pkg::OP_EXIT: ;
            default:
              if (!(in_opc >= svm_pkg::OP_OR && in_opc <= svm_pkg::OP_MOD))
                status <= svm_pkg::ST_UNSUP;
          endcase
        end
      end
      if (state == svm_pkg::S_READ) begin
        if (is_alu) sp <= sp + 1'b1;
        unique case (opc)
          svm_pkg::OP_LEV: bp <= rdata[PW-1:0];
          svm_pkg::OP_LI: acc <= rdata;
          svm_pkg::OP_LC: acc <= DataWidth'(signed'(rdata[7:0]));
          svm_pkg::OP_SI: sp <= sp + 1'b1;
          svm_pkg::OP_SC: begin
            sp <= sp + 1'b1;
            acc <= DataWidth'(signed'(acc[7:0]));
          end
          svm_pkg::OP_EXIT: begin halt <= 1'b1; exitv <= rdata; end
          svm_pkg::OP_DIV, svm_pkg::OP_MOD:
            if (acc == '0) status <= svm_pkg::ST_DIVZ;
          default: if (is_alu) acc <= alu;
        endcase
      end
      if (state == svm_pkg::S_READ2) pc <= code_of(rdata);
      if (state == svm_pkg::S_DIV && ddone) acc <= dres;
    end
  end

endmodule
